// ===== sv/mpf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_pkg: shared types and constants of the PUBLISH framer
// Command codes, header constants and the job descriptor that travels
// from the classifier through the job queue to the byte serialiser.
// ----------------------------------------------------------------------------
package mpf_pkg;

	// default width of the topic and payload length counters
	localparam int LENGTH_BITS_DEF = 16;

	// jobs held between front and back
	localparam int QUEUE_DEPTH = 4;

	// most bytes one item can cause
	localparam int MAX_BYTES = 8;

	// item commands
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_DATA  = 1'b1;

	// fixed header constants
	localparam logic [7:0] HDR_PUBLISH = 8'h30;
	localparam logic [7:0] HDR_QOS_MSK = 8'h06;
	localparam logic [7:0] HDR_RET_MSK = 8'h01;

	// one accepted item, already expanded into its bytes
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;   // bytes in send order
		logic [2:0]                cnt_m1;  // number of bytes minus one
		logic                      end_mark; // last byte closes the packet
		logic                      err;      // data byte with no packet open
	} job_t;

endpackage

// ===== sv/mpf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_front: item classifier and packet tracker
// Decodes each accepted item against the open packet, keeps the packet
// counters and hands a fully expanded job to the queue.
// ----------------------------------------------------------------------------
module mpf_front #(
	parameter int LENGTH_BITS = mpf_pkg::LENGTH_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic          cmd,
	input  logic [15:0]   topic_len,
	input  logic [15:0]   payload_len,
	input  logic [1:0]    qos,
	input  logic          retain,
	input  logic [15:0]   packet_id,
	input  logic [7:0]    data_byte,
	output mpf_pkg::job_t job
);

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_TOPIC   = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [LENGTH_BITS-1:0] topic_left_q, topic_left_d;
	logic [LENGTH_BITS-1:0] payload_left_q, payload_left_d;
	logic                   id_pending_q, id_pending_d;
	logic [15:0]            held_id_q, held_id_d;

	logic [LENGTH_BITS-1:0] tl, pl;
	logic [15:0]            tl_ext;
	logic [17:0]            rem;
	logic [1:0]             nvar;
	logic [2:0]             p_tl;
	logic                   q_nz;

	// remaining length and its varint size
	always_comb begin
		tl     = topic_len[LENGTH_BITS-1:0];
		pl     = payload_len[LENGTH_BITS-1:0];
		tl_ext = 16'(tl);
		q_nz   = (qos != 2'd0);
		rem    = 18'(tl) + 18'(pl) + 18'd2 + (q_nz ? 18'd2 : 18'd0);
		if (rem[17:14] != 4'd0) begin
			nvar = 2'd3;
		end else if (rem[13:7] != 7'd0) begin
			nvar = 2'd2;
		end else begin
			nvar = 2'd1;
		end
		p_tl = 3'd1 + 3'(nvar);
	end

	// classify the item and build its job
	always_comb begin
		job            = '0;
		phase_d        = phase_q;
		topic_left_d   = topic_left_q;
		payload_left_d = payload_left_q;
		id_pending_d   = id_pending_q;
		held_id_d      = held_id_q;
		if (cmd == mpf_pkg::CMD_START) begin
			job.bytes[0] = mpf_pkg::HDR_PUBLISH | ({5'd0, qos, 1'b0} & mpf_pkg::HDR_QOS_MSK)
				| ({7'd0, retain} & mpf_pkg::HDR_RET_MSK);
			job.bytes[1] = {(nvar != 2'd1), rem[6:0]};
			if (nvar != 2'd1) begin
				job.bytes[2] = {(nvar == 2'd3), rem[13:7]};
			end
			if (nvar == 2'd3) begin
				job.bytes[3] = {4'd0, rem[17:14]};
			end
			job.bytes[p_tl]        = tl_ext[15:8];
			job.bytes[p_tl + 3'd1] = tl_ext[7:0];
			job.cnt_m1             = p_tl + 3'd1;
			topic_left_d   = tl;
			payload_left_d = pl;
			id_pending_d   = q_nz;
			held_id_d      = packet_id;
			if (tl != '0) begin
				phase_d = PH_TOPIC;
			end else begin
				// empty topic: packet id follows straight away
				if (q_nz) begin
					job.bytes[p_tl + 3'd2] = packet_id[15:8];
					job.bytes[p_tl + 3'd3] = packet_id[7:0];
					job.cnt_m1             = p_tl + 3'd3;
				end
				id_pending_d = 1'b0;
				job.end_mark = (pl == '0);
				phase_d      = (pl != '0) ? PH_PAYLOAD : PH_IDLE;
			end
		end else begin
			case (phase_q)
				PH_TOPIC: begin
					if (topic_left_q != '0) begin
						job.bytes[0] = data_byte;
						topic_left_d = topic_left_q - LENGTH_BITS'(1);
						if (topic_left_q == LENGTH_BITS'(1)) begin
							// topic done: insert packet id, then payload or close
							if (id_pending_q) begin
								job.bytes[1] = held_id_q[15:8];
								job.bytes[2] = held_id_q[7:0];
								job.cnt_m1   = 3'd2;
							end
							id_pending_d = 1'b0;
							job.end_mark = (payload_left_q == '0);
							phase_d      = (payload_left_q != '0) ? PH_PAYLOAD : PH_IDLE;
						end
					end else begin
						job.err = 1'b1;
					end
				end
				PH_PAYLOAD: begin
					if (payload_left_q != '0) begin
						job.bytes[0]   = data_byte;
						payload_left_d = payload_left_q - LENGTH_BITS'(1);
						job.end_mark   = (payload_left_q == LENGTH_BITS'(1));
						if (payload_left_q == LENGTH_BITS'(1)) begin
							phase_d = PH_IDLE;
						end
					end else begin
						job.err = 1'b1;
					end
				end
				default: begin
					job.err = 1'b1;
				end
			endcase
		end
	end

	// hold packet state, advance on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			topic_left_q   <= '0;
			payload_left_q <= '0;
			id_pending_q   <= 1'b0;
			held_id_q      <= '0;
		end else if (accept) begin
			phase_q        <= phase_d;
			topic_left_q   <= topic_left_d;
			payload_left_q <= payload_left_d;
			id_pending_q   <= id_pending_d;
			held_id_q      <= held_id_d;
		end
	end

endmodule

// ===== sv/mpf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_queue: job queue between classifier and serialiser
// Small first-in first-out store of expanded jobs.
// ----------------------------------------------------------------------------
module mpf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  mpf_pkg::job_t wr_job,
	input  logic          rd_en,
	output logic          full,
	output logic          not_empty,
	output mpf_pkg::job_t rd_job
);

	localparam int PW = $clog2(mpf_pkg::QUEUE_DEPTH);

	mpf_pkg::job_t mem_q [mpf_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;

	assign full      = (count_q == (PW+1)'(mpf_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_job    = mem_q[rd_ptr_q];

	// store the job
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + (PW+1)'(1);
				2'b01:   count_q <= count_q - (PW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/mpf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_back: byte serialiser
// Walks the head job one byte per cycle into the result register, while that
// register is empty or being popped, and releases the job after its last byte.
// ----------------------------------------------------------------------------
module mpf_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  mpf_pkg::job_t head_job,
	input  logic          pop,
	output logic          head_done,
	output logic          empty,
	output logic [7:0]    out_byte,
	output logic          run_last,
	output logic          packet_end,
	output logic          error
);

	logic [2:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q, end_q, err_q;
	logic       advance, is_last;

	assign advance   = head_valid && (!valid_q || pop);
	assign is_last   = (idx_q == head_job.cnt_m1);
	assign head_done = advance && is_last;

	assign empty      = !valid_q;
	assign out_byte   = byte_q;
	assign run_last   = last_q;
	assign packet_end = end_q;
	assign error      = err_q;

	// step through the bytes of the head job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				idx_q   <= is_last ? 3'd0 : idx_q + 3'd1;
				valid_q <= 1'b1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	// load the result register
	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q <= head_job.bytes[idx_q];
			last_q <= is_last;
			end_q  <= is_last && head_job.end_mark;
			err_q  <= head_job.err;
		end
	end

endmodule

// ===== sv/mqtt_publish_framer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqtt_publish_framer_unit: MQTT PUBLISH packet framer
// Turns start and data items into the encoded PUBLISH byte stream.
//
//   channel  direction  handshake            fields
//   input    in         push / full          cmd topic_len payload_len qos
//                                            retain packet_id data_byte
//   result   out        empty / pop          out_byte run_last packet_end error
//
// A data item yields one byte (three when the packet id follows the topic)
// and the serialiser sends one byte per cycle while the result is empty or
// popped. A start item yields four to eight bytes; the four-entry job queue
// keeps taking items while the serialiser is busy, until it is full. With the
// serialiser free, an accepted item is written to the job queue and its first
// byte is then loaded into the result register, from which it can be popped.
// Reset clears the packet state, the queue and the result valid flag.
// ----------------------------------------------------------------------------
module mqtt_publish_framer_unit #(
	parameter int LENGTH_BITS = mpf_pkg::LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        cmd,
	input  logic [15:0] topic_len,
	input  logic [15:0] payload_len,
	input  logic [1:0]  qos,
	input  logic        retain,
	input  logic [15:0] packet_id,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        run_last,
	output logic        packet_end,
	output logic        error
);

	mpf_pkg::job_t new_job, head_job;
	logic          accept, head_valid, head_done;

	assign accept = push && !full;

	// classify items
	mpf_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.cmd        (cmd),
		.topic_len  (topic_len),
		.payload_len(payload_len),
		.qos        (qos),
		.retain     (retain),
		.packet_id  (packet_id),
		.data_byte  (data_byte),
		.job        (new_job)
	);

	// hold jobs between the two sides
	mpf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.wr_job   (new_job),
		.rd_en    (head_done),
		.full     (full),
		.not_empty(head_valid),
		.rd_job   (head_job)
	);

	// send bytes
	mpf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_job  (head_job),
		.pop       (pop),
		.head_done (head_done),
		.empty     (empty),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.packet_end(packet_end),
		.error     (error)
	);

endmodule
